[rtl/qdvk_pkg.sv]
// shared types, codes and helper functions for the quadrature detent value knob
package qdvk_pkg;

    localparam int unsigned ValW  = 32;
    localparam int unsigned StepW = 31;
    localparam int unsigned TpdW  = 4;
    localparam int unsigned CntW  = 5;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned WideW = 34;

    localparam logic signed [ValW-1:0]  MinLimitRst = 32'sd0;
    localparam logic signed [ValW-1:0]  MaxLimitRst = 32'sd6553600;
    localparam logic [StepW-1:0]        StepSizeRst = 31'd65536;
    localparam logic [TpdW-1:0]         TpdRst      = 4'd4;
    localparam logic [1:0]              LastCodeRst = 2'b11;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_RESYNC = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        EVT_NONE = 2'd0,
        EVT_INC  = 2'd1,
        EVT_DEC  = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2,
        DIR_JUMP = 2'd3
    } t_dir;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MIN_LIMIT = 3'd0,
        CFG_MAX_LIMIT = 3'd1,
        CFG_STEP_SIZE = 3'd2,
        CFG_TPD       = 3'd3,
        CFG_REVERSE   = 3'd4
    } t_cfg_idx;

    // clockwise successor in the 00-01-11-10 gray sequence
    function automatic logic [1:0] cw_next(input logic [1:0] code);
        logic [1:0] nxt;
        unique case (code)
            2'b00: nxt = 2'b01;
            2'b01: nxt = 2'b11;
            2'b11: nxt = 2'b10;
            2'b10: nxt = 2'b00;
            default: nxt = 2'b00;
        endcase
        return nxt;
    endfunction

    function automatic t_dir gray_dir(input logic [1:0] from, input logic [1:0] to);
        t_dir dir;
        if (from == to) begin
            dir = DIR_NONE;
        end else if (to == cw_next(from)) begin
            dir = DIR_CW;
        end else if (from == cw_next(to)) begin
            dir = DIR_CCW;
        end else begin
            dir = DIR_JUMP;
        end
        return dir;
    endfunction

    // clamp a wide value into the range spanned by the two limits
    function automatic logic signed [ValW-1:0] clamp_val(
        input logic signed [WideW-1:0] v,
        input logic signed [ValW-1:0]  lim_a,
        input logic signed [ValW-1:0]  lim_b
    );
        logic signed [ValW-1:0] lo;
        logic signed [ValW-1:0] hi;
        logic signed [ValW-1:0] res;
        if (lim_a > lim_b) begin
            lo = lim_b;
            hi = lim_a;
        end else begin
            lo = lim_a;
            hi = lim_b;
        end
        if (v > WideW'(hi)) begin
            res = hi;
        end else if (v < WideW'(lo)) begin
            res = lo;
        end else begin
            res = v[ValW-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/qdvk_in_if.sv]
// input channel: one command or pin sample word
interface qdvk_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       func;
    logic                             pin_a;
    logic                             pin_b;
    logic signed [qdvk_pkg::ValW-1:0] new_value;

    modport source (output valid, output func, output pin_a, output pin_b,
                    output new_value, input ready);
    modport sink   (input valid, input func, input pin_a, input pin_b,
                    input new_value, output ready);
endinterface

[rtl/qdvk_out_if.sv]
// output channel: one knob result word
interface qdvk_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [qdvk_pkg::ValW-1:0] knob_value;
    logic [1:0]                       detent_event;
    logic                             invalid_step;

    modport source (output valid, output knob_value, output detent_event,
                    output invalid_step, input ready);
    modport sink   (input valid, input knob_value, input detent_event,
                    input invalid_step, output ready);
endinterface

[rtl/quadrature_detent_value_knob.sv]
// quadrature encoder to clamped q16.16 value knob, top level
//
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+-------------
//  i_in     | in  | func, pin_a, pin_b, new_value            | valid/ready
//  o_out    | out | knob_value, detent_event, invalid_step   | valid/ready
//  i_cfg_*  | in  | i_cfg_idx, i_cfg_data                    | i_cfg_we only
//
// one word accepted per cycle while o_out is not stalled; its result word appears in the next cycle
// the state update (decode, count, clamp, step, clamp) is a single combinational pass into
// the state registers and the output register
// i_in.ready drops only while a result word sits in o_out and is not taken
// synchronous active-low reset restores the register defaults and last code 11
module quadrature_detent_value_knob (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    qdvk_in_if.sink                               i_in,
    qdvk_out_if.source                            o_out,
    input  logic                                  i_cfg_we,
    input  logic [qdvk_pkg::CfgIdxW-1:0]          i_cfg_idx,
    input  logic [qdvk_pkg::ValW-1:0]             i_cfg_data
);

    // configuration registers
    logic signed [qdvk_pkg::ValW-1:0]  r_min_limit;
    logic signed [qdvk_pkg::ValW-1:0]  r_max_limit;
    logic [qdvk_pkg::StepW-1:0]        r_step_size;
    logic [qdvk_pkg::TpdW-1:0]         r_tpd;
    logic                              r_reverse;

    // decoder state
    logic [1:0]                        r_last_code;
    logic [1:0]                        n_last_code;
    logic signed [qdvk_pkg::CntW-1:0]  r_count;
    logic signed [qdvk_pkg::CntW-1:0]  n_count;
    logic signed [qdvk_pkg::ValW-1:0]  r_held;
    logic signed [qdvk_pkg::ValW-1:0]  n_held;

    // output register
    logic                              r_out_valid;
    logic signed [qdvk_pkg::ValW-1:0]  r_knob;
    logic signed [qdvk_pkg::ValW-1:0]  n_knob;
    qdvk_pkg::t_event                  r_event;
    qdvk_pkg::t_event                  n_event;
    logic                              r_invalid;
    logic                              n_invalid;

    logic                              in_accept;
    logic [1:0]                        code;
    qdvk_pkg::t_dir                    dir;
    logic                              count_up;
    logic signed [qdvk_pkg::CntW:0]    cnt_sum;
    logic signed [qdvk_pkg::CntW:0]    tpd_pos;
    logic                              hit_up;
    logic                              hit_down;
    logic signed [qdvk_pkg::ValW-1:0]  cur_clamped;
    logic signed [qdvk_pkg::WideW-1:0] step_wide;
    logic signed [qdvk_pkg::WideW-1:0] moved;
    logic signed [qdvk_pkg::WideW-1:0] load_wide;
    logic signed [qdvk_pkg::ValW-1:0]  load_clamped;

    // accept when the output slot is empty or being emptied this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    assign code = {i_in.pin_a, i_in.pin_b};
    assign dir  = qdvk_pkg::gray_dir(r_last_code, code);

    // reverse flips which gray direction counts upward
    assign count_up = (dir == qdvk_pkg::DIR_CW) ^ r_reverse;
    assign cnt_sum  = {r_count[qdvk_pkg::CntW-1], r_count}
                    + (count_up ? 6'sd1 : -6'sd1);
    assign tpd_pos  = $signed({2'b00, r_tpd});
    assign hit_up   = cnt_sum >= tpd_pos;
    assign hit_down = cnt_sum <= -tpd_pos;

    // reported value and detent base both use the held value clamped to the
    // present limits, since the limits may have moved since it was stored
    assign cur_clamped = qdvk_pkg::clamp_val(qdvk_pkg::WideW'(r_held),
                                             r_min_limit, r_max_limit);
    assign step_wide   = $signed({3'b000, r_step_size});
    assign moved       = hit_up ? qdvk_pkg::WideW'(cur_clamped) + step_wide
                                : qdvk_pkg::WideW'(cur_clamped) - step_wide;

    // one shared clamp for detent steps and value loads
    assign load_wide    = (i_in.func == qdvk_pkg::FUNC_SET)
                        ? qdvk_pkg::WideW'(i_in.new_value) : moved;
    assign load_clamped = qdvk_pkg::clamp_val(load_wide, r_min_limit, r_max_limit);

    always_comb begin
        n_last_code = r_last_code;
        n_count     = r_count;
        n_held      = r_held;
        n_knob      = cur_clamped;
        n_event     = qdvk_pkg::EVT_NONE;
        n_invalid   = 1'b0;
        unique case (i_in.func)
            qdvk_pkg::FUNC_SAMPLE: begin
                unique case (dir)
                    qdvk_pkg::DIR_NONE: begin
                        // unchanged sample, nothing moves
                    end
                    qdvk_pkg::DIR_JUMP: begin
                        n_count     = '0;
                        n_invalid   = 1'b1;
                        n_last_code = code;
                    end
                    qdvk_pkg::DIR_CW, qdvk_pkg::DIR_CCW: begin
                        n_last_code = code;
                        priority if (hit_up) begin
                            n_count = '0;
                            n_held  = load_clamped;
                            n_knob  = load_clamped;
                            n_event = qdvk_pkg::EVT_INC;
                        end else if (hit_down) begin
                            n_count = '0;
                            n_held  = load_clamped;
                            n_knob  = load_clamped;
                            n_event = qdvk_pkg::EVT_DEC;
                        end else begin
                            n_count = cnt_sum[qdvk_pkg::CntW-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            qdvk_pkg::FUNC_SET: begin
                n_held  = load_clamped;
                n_knob  = load_clamped;
                n_count = '0;
            end
            qdvk_pkg::FUNC_RESYNC: begin
                n_last_code = code;
            end
            default: begin
                // unused code: report only
            end
        endcase
    end

    // state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_limit <= qdvk_pkg::MinLimitRst;
            r_max_limit <= qdvk_pkg::MaxLimitRst;
            r_step_size <= qdvk_pkg::StepSizeRst;
            r_tpd       <= qdvk_pkg::TpdRst;
            r_reverse   <= 1'b0;
            r_last_code <= qdvk_pkg::LastCodeRst;
            r_count     <= '0;
            r_held      <= '0;
        end else begin
            if (in_accept) begin
                r_last_code <= n_last_code;
                r_count     <= n_count;
                r_held      <= n_held;
            end
            // limit writes also drop any partial detent
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    qdvk_pkg::CFG_MIN_LIMIT: begin
                        r_min_limit <= $signed(i_cfg_data);
                        r_count     <= '0;
                    end
                    qdvk_pkg::CFG_MAX_LIMIT: begin
                        r_max_limit <= $signed(i_cfg_data);
                        r_count     <= '0;
                    end
                    qdvk_pkg::CFG_STEP_SIZE: r_step_size <= i_cfg_data[qdvk_pkg::StepW-1:0];
                    qdvk_pkg::CFG_TPD:       r_tpd       <= i_cfg_data[qdvk_pkg::TpdW-1:0];
                    qdvk_pkg::CFG_REVERSE:   r_reverse   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // output register: valid is control, the word itself needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_knob    <= n_knob;
            r_event   <= n_event;
            r_invalid <= n_invalid;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.knob_value   = r_knob;
    assign o_out.detent_event = r_event;
    assign o_out.invalid_step = r_invalid;

endmodule

[rtl/qdvk_chk.sv]
// port-level checker for the quadrature detent value knob, with its bind
module qdvk_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic [1:0]                       i_in_func,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic signed [qdvk_pkg::ValW-1:0] i_knob_value,
    input logic [1:0]                       i_detent_event,
    input logic                             i_invalid_step
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_knob_value)
            && $stable(i_detent_event) && $stable(i_invalid_step))
        else $error("result word changed while stalled");

    // an empty output slot never blocks input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output slot");

    // every accepted word yields a result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted word produced no result");

    // only pin samples raise events or invalid flags
    a_nonsample_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_func != qdvk_pkg::FUNC_SAMPLE)
            |=> (i_detent_event == qdvk_pkg::EVT_NONE) && !i_invalid_step)
        else $error("event flagged for a non-sample word");

    // a jump never coincides with a detent, and event code 3 never shows
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_invalid_step && (i_detent_event != qdvk_pkg::EVT_NONE))
            && (i_detent_event != 2'd3))
        else $error("inconsistent result flags");

endmodule

bind quadrature_detent_value_knob qdvk_chk u_qdvk_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_func      (i_in.func),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_knob_value   (o_out.knob_value),
    .i_detent_event (o_out.detent_event),
    .i_invalid_step (o_out.invalid_step)
);
